/* hdl/qpe_pkg.sv */
`default_nettype none

package qpe_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_MAX_LEN = 3'd1;
  localparam logic [2:0] REG_MASK_0  = 3'd2;
  localparam logic [2:0] REG_MASK_1  = 3'd3;
  localparam logic [2:0] REG_MASK_2  = 3'd4;
  localparam logic [2:0] REG_MASK_3  = 3'd5;

  localparam logic [1:0] MODE_CRLF   = 2'd0;
  localparam logic [1:0] MODE_LF     = 2'd1;
  localparam logic [1:0] MODE_MIXED  = 2'd2;
  localparam logic [1:0] MODE_BINARY = 2'd3;

  localparam logic [6:0] MAX_LEN_RESET = 7'd76;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_BANG  = 8'd33;
  localparam logic [7:0] CHAR_EQ    = 8'd61;
  localparam logic [7:0] CHAR_TILDE = 8'd126;

  typedef enum logic [2:0] {
    CLS_PC,
    CLS_CC,
    CLS_WS,
    CLS_CR,
    CLS_LF
  } cls_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRINT,
    OP_HEX,
    OP_HARD,
    OP_ERR
  } op_kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_t;

  typedef struct packed {
    logic [1:0]   mode;
    logic [6:0]   max_len;
    logic [255:0] mask;
  } cfg_t;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       flush;
  } op_t;

  typedef struct packed {
    op_t op0;
    op_t op1;
  } entry_t;

  function automatic cls_e classify(input logic [7:0] b, input cfg_t cfg);
    cls_e c;
    if (b == CHAR_CR) begin
      c = (cfg.mode == MODE_CRLF || cfg.mode == MODE_MIXED) ? CLS_CR : CLS_CC;
    end else if (b == CHAR_LF) begin
      c = (cfg.mode == MODE_BINARY) ? CLS_CC : CLS_LF;
    end else begin
      if (b == CHAR_TAB || b == CHAR_SPACE) begin
        c = CLS_WS;
      end else if (b >= CHAR_BANG && b <= CHAR_TILDE && b != CHAR_EQ) begin
        c = CLS_PC;
      end else begin
        c = CLS_CC;
      end
      if (c != CLS_CC && cfg.mask[b]) begin
        c = CLS_CC;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

`default_nettype wire

/* hdl/qpe_front.sv */
`default_nettype none

module qpe_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qpe_pkg::cfg_t  cfg_i,
  input  wire qpe_pkg::in_t   in_i,
  input  wire logic           accept_i,
  output qpe_pkg::entry_t     ent_o,
  output logic                ent_vld_o
);

  logic [7:0]      held_q, held_d;
  logic            held_vld_q, held_vld_d;
  logic            done_q, done_d;
  logic            err_q, err_d;
  qpe_pkg::cls_e   cls;
  qpe_pkg::op_t    op_a, op_b, op_none;
  logic            consumed;

  assign op_none = '{kind: qpe_pkg::OP_NONE, data: 8'h00, flush: 1'b0};

  always_comb begin
    cls        = qpe_pkg::classify(in_i.data_byte, cfg_i);
    op_a       = op_none;
    op_b       = op_none;
    consumed   = 1'b0;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    done_d     = done_q;
    err_d      = err_q;
    if (accept_i) begin
      if (err_q || done_q) begin
        err_d = 1'b1;
        op_a  = '{kind: qpe_pkg::OP_ERR, data: 8'h00, flush: 1'b0};
      end else if (in_i.command) begin
        done_d = 1'b1;
        if (held_vld_q) begin
          op_a       = '{kind: qpe_pkg::OP_HEX, data: held_q, flush: 1'b1};
          held_vld_d = 1'b0;
          held_d     = 8'h00;
        end
      end else begin
        if (held_vld_q) begin
          if (held_q == qpe_pkg::CHAR_CR) begin
            if (cls == qpe_pkg::CLS_LF) begin
              op_a     = '{kind: qpe_pkg::OP_HARD, data: 8'h00, flush: 1'b0};
              consumed = 1'b1;
            end else begin
              op_a = '{kind: qpe_pkg::OP_HEX, data: held_q, flush: 1'b0};
            end
          end else if (cls == qpe_pkg::CLS_LF || cls == qpe_pkg::CLS_CR) begin
            op_a = '{kind: qpe_pkg::OP_HEX, data: held_q, flush: 1'b0};
          end else begin
            op_a = '{kind: qpe_pkg::OP_PRINT, data: held_q, flush: 1'b0};
          end
          held_vld_d = 1'b0;
          held_d     = 8'h00;
        end
        if (!consumed) begin
          case (cls)
            qpe_pkg::CLS_PC: begin
              op_b = '{kind: qpe_pkg::OP_PRINT, data: in_i.data_byte, flush: 1'b0};
            end
            qpe_pkg::CLS_WS, qpe_pkg::CLS_CR: begin
              held_d     = in_i.data_byte;
              held_vld_d = 1'b1;
            end
            qpe_pkg::CLS_LF: begin
              if (cfg_i.mode == qpe_pkg::MODE_LF || cfg_i.mode == qpe_pkg::MODE_MIXED) begin
                op_b = '{kind: qpe_pkg::OP_HARD, data: 8'h00, flush: 1'b0};
              end else begin
                op_b = '{kind: qpe_pkg::OP_HEX, data: in_i.data_byte, flush: 1'b0};
              end
            end
            default: begin
              op_b = '{kind: qpe_pkg::OP_HEX, data: in_i.data_byte, flush: 1'b0};
            end
          endcase
        end
      end
    end
  end

  // first op always in slot 0
  always_comb begin
    if (op_a.kind != qpe_pkg::OP_NONE) begin
      ent_o.op0 = op_a;
      ent_o.op1 = op_b;
    end else begin
      ent_o.op0 = op_b;
      ent_o.op1 = op_none;
    end
    ent_vld_o = accept_i && (ent_o.op0.kind != qpe_pkg::OP_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 8'h00;
      held_vld_q <= 1'b0;
      done_q     <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      done_q     <= done_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/qpe_queue.sv */
`default_nettype none

module qpe_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire qpe_pkg::entry_t  wdata_i,
  input  wire logic             rd_i,
  output qpe_pkg::entry_t       rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  qpe_pkg::entry_t                  mem_q [qpe_pkg::QueueDepth];
  logic [qpe_pkg::QueuePtrW-1:0]    wptr_q, rptr_q;
  logic [qpe_pkg::QueueCntW-1:0]    cnt_q;
  logic                             do_wr, do_rd;

  assign full_o  = (cnt_q == qpe_pkg::QueueCntW'(qpe_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/qpe_back.sv */
`default_nettype none

module qpe_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire qpe_pkg::cfg_t    cfg_i,
  input  wire qpe_pkg::entry_t  head_i,
  input  wire logic             head_vld_i,
  output logic                  head_pop_o,
  input  wire logic             pop,
  output logic                  empty,
  output qpe_pkg::out_t         out_o
);

  logic          sel_q;
  logic [2:0]    step_q;
  logic          pre_q;
  logic [6:0]    col_q;
  logic          lws_q;
  qpe_pkg::out_t out_q;
  logic          out_vld_q;

  qpe_pkg::op_t  cur;
  logic          adv;
  logic          sb;
  logic          pre;
  logic [2:0]    len;
  logic [2:0]    j;
  logic          at_end;
  logic          op_final;
  logic [7:0]    byte_c;
  logic [6:0]    base;

  always_comb begin
    cur      = sel_q ? head_i.op1 : head_i.op0;
    adv      = head_vld_i && (!out_vld_q || pop);
    sb       = 1'b0;
    case (cur.kind)
      qpe_pkg::OP_PRINT: sb = ({1'b0, col_q} + 8'd1) >= {1'b0, cfg_i.max_len};
      qpe_pkg::OP_HEX:   sb = ({1'b0, col_q} + (cur.flush ? 8'd2 : 8'd3))
                              >= {1'b0, cfg_i.max_len};
      qpe_pkg::OP_HARD:  sb = lws_q;
      default:           sb = 1'b0;
    endcase
    pre = (step_q == 3'd0) ? sb : pre_q;
    case (cur.kind)
      qpe_pkg::OP_HEX:  len = 3'd3;
      qpe_pkg::OP_HARD: len = 3'd2;
      default:          len = 3'd1;
    endcase
    if (pre) begin
      len = len + 3'd3;
    end
    j        = pre ? (step_q - 3'd3) : step_q;
    at_end   = (step_q == len - 3'd1);
    op_final = sel_q || (head_i.op1.kind == qpe_pkg::OP_NONE);
    byte_c   = 8'h00;
    if (pre && step_q < 3'd3) begin
      case (step_q)
        3'd0:    byte_c = qpe_pkg::CHAR_EQ;
        3'd1:    byte_c = qpe_pkg::CHAR_CR;
        default: byte_c = qpe_pkg::CHAR_LF;
      endcase
    end else begin
      case (cur.kind)
        qpe_pkg::OP_PRINT: byte_c = cur.data;
        qpe_pkg::OP_HEX: begin
          case (j)
            3'd0:    byte_c = qpe_pkg::CHAR_EQ;
            3'd1:    byte_c = qpe_pkg::hex_char(cur.data[7:4]);
            default: byte_c = qpe_pkg::hex_char(cur.data[3:0]);
          endcase
        end
        qpe_pkg::OP_HARD: byte_c = (j == 3'd0) ? qpe_pkg::CHAR_CR : qpe_pkg::CHAR_LF;
        default:          byte_c = 8'h00;
      endcase
    end
    base       = (pre && cur.kind != qpe_pkg::OP_HARD) ? 7'd0 : col_q;
    head_pop_o = adv && at_end && op_final;
  end

  assign empty = !out_vld_q;
  assign out_o = out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_byte <= byte_c;
      out_q.last     <= at_end && op_final;
      out_q.error    <= (cur.kind == qpe_pkg::OP_ERR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 1'b0;
      step_q    <= 3'd0;
      pre_q     <= 1'b0;
      col_q     <= 7'd0;
      lws_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        pre_q <= pre;
        if (at_end) begin
          step_q <= 3'd0;
          sel_q  <= !op_final;
          case (cur.kind)
            qpe_pkg::OP_PRINT: begin
              col_q <= base + 7'd1;
              lws_q <= (qpe_pkg::classify(cur.data, cfg_i) == qpe_pkg::CLS_WS);
            end
            qpe_pkg::OP_HEX: begin
              col_q <= base + 7'd3;
              lws_q <= 1'b0;
            end
            qpe_pkg::OP_HARD: begin
              col_q <= 7'd0;
              lws_q <= 1'b0;
            end
            default: begin
              col_q <= col_q;
            end
          endcase
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/quoted_printable_encoder.sv */
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------
// input     | push / full          | in_i  : command, data_byte
// result    | empty / pop          | out_o : out_byte, last, error
// config    | cfg_we_i, cfg_idx_i  | cfg_data_i (64 bits, low bits for mode/len)
//
// one result beat per cycle while ops are queued and pop keeps up; an item is
// accepted by the front and then yields 0 to 12 beats in the back end (1 per
// printable, 1 per error, 3 per escape, 2 per hard break, plus 3 per soft break),
// paced by the byte sequencer; a four-entry op queue lets the front take items while the back drains
// reset clears config to defaults and the encoder to start of line
// pop low holds the result register; push stalls only when the queue is full
`default_nettype none

module quoted_printable_encoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire qpe_pkg::in_t in_i,
  output logic              empty,
  input  wire logic         pop,
  output qpe_pkg::out_t     out_o,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i
);

  qpe_pkg::cfg_t    cfg_q;
  qpe_pkg::entry_t  ent, head;
  logic             ent_vld;
  logic             head_pop;
  logic             q_empty;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= qpe_pkg::MODE_CRLF;
      cfg_q.max_len <= qpe_pkg::MAX_LEN_RESET;
      cfg_q.mask    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qpe_pkg::REG_MODE:    cfg_q.mode           <= cfg_data_i[1:0];
        qpe_pkg::REG_MAX_LEN: cfg_q.max_len        <= cfg_data_i[6:0];
        qpe_pkg::REG_MASK_0:  cfg_q.mask[63:0]     <= cfg_data_i;
        qpe_pkg::REG_MASK_1:  cfg_q.mask[127:64]   <= cfg_data_i;
        qpe_pkg::REG_MASK_2:  cfg_q.mask[191:128]  <= cfg_data_i;
        qpe_pkg::REG_MASK_3:  cfg_q.mask[255:192]  <= cfg_data_i;
        default:              cfg_q                <= cfg_q;
      endcase
    end
  end

  assign accept = push && !full;

  qpe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .accept_i  (accept),
    .ent_o     (ent),
    .ent_vld_o (ent_vld)
  );

  qpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ent_vld),
    .wdata_i (ent),
    .rd_i    (head_pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  qpe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .head_vld_i (!q_empty),
    .head_pop_o (head_pop),
    .pop        (pop),
    .empty      (empty),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

/* hdl/qpe_checker.sv */
`default_nettype none

module qpe_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          empty,
  input wire logic          pop,
  input wire qpe_pkg::out_t out_o
);

  // waiting beat is not dropped
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_o))
    else $error("result beat changed while stalled");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.error |-> out_o.out_byte == 8'h00 && out_o.last)
    else $error("error beat malformed");

  a_char_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_o.error |-> out_o.out_byte != 8'h00 && !out_o.out_byte[7])
    else $error("encoded byte outside ascii range");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (.*);

`default_nettype wire
